// File: hw/rtl/jsu_pkg.sv
// shared codes, types and lookup functions for the json string unescaper
package jsu_pkg;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_TEXT = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  localparam logic [1:0] KIND_DATA       = 2'd0;
  localparam logic [1:0] KIND_END        = 2'd1;
  localparam logic [1:0] KIND_NOT_STRING = 2'd2;

  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHAR_SLASH     = 8'h2f;
  localparam logic [7:0] CHAR_U         = 8'h75;
  localparam logic [7:0] CHAR_B         = 8'h62;
  localparam logic [7:0] CHAR_F         = 8'h66;
  localparam logic [7:0] CHAR_N         = 8'h6e;
  localparam logic [7:0] CHAR_R         = 8'h72;
  localparam logic [7:0] CHAR_T         = 8'h74;

  localparam logic [1:0] HEX_LAST = 2'd3;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [1:0]      kind;
    logic [2:0][7:0] bytes;
  } grp_t;

  typedef struct packed {
    logic       known;
    logic [7:0] value;
  } esc_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) v = c[3:0] + 4'd9;
    return v;
  endfunction

  function automatic esc_t escape_byte(input logic [7:0] c);
    esc_t e;
    e.known = 1'b1;
    e.value = 8'h00;
    unique case (c)
      CHAR_QUOTE:     e.value = CHAR_QUOTE;
      CHAR_BACKSLASH: e.value = CHAR_BACKSLASH;
      CHAR_SLASH:     e.value = CHAR_SLASH;
      CHAR_B:         e.value = 8'h08;
      CHAR_F:         e.value = 8'h0c;
      CHAR_N:         e.value = 8'h0a;
      CHAR_R:         e.value = 8'h0d;
      CHAR_T:         e.value = 8'h09;
      default:        e.known = 1'b0;
    endcase
    return e;
  endfunction

endpackage

// File: hw/rtl/json_string_unescape.sv
// json string unescaper top level: input register, decode, result group register
// Takes one byte per cycle when not stalled, starting at the opening quote, and gives the
// unescaped text as utf-8 bytes with a kind code (data, end of string, not a string) and a
// last flag on the final result of each byte. The input register and the result group
// register each hold one item, so a new byte is taken in every cycle while the output keeps
// up. A \u escape yields up to three results from its fourth hex digit, which leave one
// per cycle from the group register while the output keeps up; the input then stalls
// only while a multi-byte group is still draining. A group held by a stalled output
// holds off any byte that gives results. Bytes that give none (opening quote, backslash,
// u, first three hex digits) pass through without waiting on the output.
module json_string_unescape (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);
  import jsu_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_load;

  grp_t       dec_grp;
  grp_t       grp_q;
  logic       grp_valid_q, grp_valid_d;
  logic [1:0] idx_q, idx_d;
  logic       take, grp_done, grp_free, adv, grp_load;

  jsu_decode u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (in_byte_q),
    .grp_o  (dec_grp)
  );

  assign last_o   = (idx_q == grp_q.cnt - 2'd1);
  assign take     = grp_valid_q && !out_stall_i;
  assign grp_done = take && last_o;
  assign grp_free = !grp_valid_q || grp_done;
  assign adv      = in_valid_q && ((dec_grp.cnt == 2'd0) || grp_free);
  assign grp_load = adv && (dec_grp.cnt != 2'd0);

  assign in_stall_o = in_valid_q && !adv;
  assign in_load    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_load) in_valid_d = 1'b1;
    else if (adv) in_valid_d = 1'b0;
  end

  always_comb begin
    grp_valid_d = grp_valid_q;
    idx_d       = idx_q;
    if (grp_load) begin
      grp_valid_d = 1'b1;
      idx_d       = 2'd0;
    end else if (grp_done) begin
      grp_valid_d = 1'b0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      grp_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      grp_valid_q <= grp_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) in_byte_q <= in_byte_i;
    if (grp_load) grp_q <= dec_grp;
  end

  assign out_valid_o = grp_valid_q;
  assign kind_o      = grp_q.kind;

  always_comb begin
    unique case (idx_q)
      2'd0:    out_byte_o = grp_q.bytes[0];
      2'd1:    out_byte_o = grp_q.bytes[1];
      default: out_byte_o = grp_q.bytes[2];
    endcase
  end

`ifndef SYNTHESIS
  a_grp_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_q |-> (grp_q.cnt != 2'd0 && idx_q < grp_q.cnt))
    else $error("result group empty or index past its count");

  a_marker_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_DATA) |-> (last_o && out_byte_o == 8'h00))
    else $error("end or not-a-string result not a lone zero result");

  a_drain_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> (out_valid_o && idx_q == $past(idx_q) + 2'd1))
    else $error("multi-byte group did not advance to its next result");
`endif

endmodule

// File: hw/rtl/jsu_decode.sv
// string state and per-byte decode into a group of up to three results
module jsu_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic [7:0]    byte_i,
  output jsu_pkg::grp_t grp_o
);
  import jsu_pkg::*;

  logic [1:0]  mode_q, mode_d;
  logic [1:0]  hex_q, hex_d;
  logic [15:0] cp_q, cp_d;
  logic [15:0] cp_next;
  esc_t        esc;

  assign cp_next = {cp_q[11:0], hex_value(byte_i)};
  assign esc     = escape_byte(byte_i);

  always_comb begin
    mode_d = mode_q;
    hex_d  = hex_q;
    cp_d   = cp_q;
    grp_o  = '0;
    unique case (mode_q)
      MODE_IDLE: begin
        if (byte_i == CHAR_QUOTE) begin
          mode_d = MODE_TEXT;
        end else begin
          grp_o.cnt  = 2'd1;
          grp_o.kind = KIND_NOT_STRING;
        end
      end
      MODE_TEXT: begin
        if (byte_i == CHAR_QUOTE) begin
          mode_d     = MODE_IDLE;
          grp_o.cnt  = 2'd1;
          grp_o.kind = KIND_END;
        end else if (byte_i == CHAR_BACKSLASH) begin
          mode_d = MODE_ESC;
        end else begin
          grp_o.cnt      = 2'd1;
          grp_o.bytes[0] = byte_i;
        end
      end
      MODE_ESC: begin
        if (byte_i == CHAR_U) begin
          mode_d = MODE_HEX;
          hex_d  = 2'd0;
          cp_d   = 16'd0;
        end else begin
          mode_d = MODE_TEXT;
          if (esc.known) begin
            grp_o.cnt      = 2'd1;
            grp_o.bytes[0] = esc.value;
          end
        end
      end
      MODE_HEX: begin
        cp_d = cp_next;
        if (hex_q != HEX_LAST) begin
          hex_d = hex_q + 2'd1;
        end else begin
          hex_d  = 2'd0;
          mode_d = MODE_TEXT;
          // utf-8 encode, one to three bytes
          if (cp_next[15:7] == 9'd0) begin
            grp_o.cnt      = 2'd1;
            grp_o.bytes[0] = {1'b0, cp_next[6:0]};
          end else if (cp_next[15:11] == 5'd0) begin
            grp_o.cnt      = 2'd2;
            grp_o.bytes[0] = {3'b110, cp_next[10:6]};
            grp_o.bytes[1] = {2'b10, cp_next[5:0]};
          end else begin
            grp_o.cnt      = 2'd3;
            grp_o.bytes[0] = {4'b1110, cp_next[15:12]};
            grp_o.bytes[1] = {2'b10, cp_next[11:6]};
            grp_o.bytes[2] = {2'b10, cp_next[5:0]};
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      hex_q  <= 2'd0;
      cp_q   <= 16'd0;
    end else if (adv_i) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
      cp_q   <= cp_d;
    end
  end

endmodule

// File: bench/jsu_unescape_sb_pkg.sv
// scoreboard for the json string unescaper: byte-level decode predictor and result checker
`timescale 1ns / 100ps

package jsu_unescape_sb_pkg;

  import jsu_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } unesc_res_t;

  class unescape_scoreboard;

    logic [1:0]  mode;
    logic [1:0]  hex_cnt;
    logic [15:0] code_pt;
    unesc_res_t  expected_q[$];
    int unsigned mismatches;

    function new();
      mode = MODE_IDLE;
      hex_cnt = 2'd0;
      code_pt = 16'd0;
      mismatches = 0;
    endfunction

    function void add_result(logic [1:0] kind, logic [7:0] data, logic last);
      unesc_res_t r;
      r.kind = kind;
      r.data = data;
      r.last = last;
      expected_q.push_back(r);
    endfunction

    function logic [3:0] nibble_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
      return 4'd0;
    endfunction

    function void emit_utf8(logic [15:0] cp);
      if (cp < 16'h0080) begin
        add_result(KIND_DATA, cp[7:0], 1'b1);
      end else if (cp < 16'h0800) begin
        add_result(KIND_DATA, {3'b110, cp[10:6]}, 1'b0);
        add_result(KIND_DATA, {2'b10, cp[5:0]}, 1'b1);
      end else begin
        add_result(KIND_DATA, {4'b1110, cp[15:12]}, 1'b0);
        add_result(KIND_DATA, {2'b10, cp[11:6]}, 1'b0);
        add_result(KIND_DATA, {2'b10, cp[5:0]}, 1'b1);
      end
    endfunction

    // one accepted input transfer
    function void note_byte(logic [7:0] c);
      case (mode)
        MODE_IDLE: begin
          if (c == CHAR_QUOTE) mode = MODE_TEXT;
          else add_result(KIND_NOT_STRING, 8'h00, 1'b1);
        end
        MODE_TEXT: begin
          if (c == CHAR_QUOTE) begin
            mode = MODE_IDLE;
            add_result(KIND_END, 8'h00, 1'b1);
          end else if (c == CHAR_BACKSLASH) begin
            mode = MODE_ESC;
          end else begin
            add_result(KIND_DATA, c, 1'b1);
          end
        end
        MODE_ESC: begin
          if (c == CHAR_U) begin
            mode = MODE_HEX;
            hex_cnt = 2'd0;
            code_pt = 16'd0;
          end else begin
            mode = MODE_TEXT;
            case (c)
              CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: add_result(KIND_DATA, c, 1'b1);
              CHAR_B: add_result(KIND_DATA, 8'h08, 1'b1);
              CHAR_F: add_result(KIND_DATA, 8'h0c, 1'b1);
              CHAR_N: add_result(KIND_DATA, 8'h0a, 1'b1);
              CHAR_R: add_result(KIND_DATA, 8'h0d, 1'b1);
              CHAR_T: add_result(KIND_DATA, 8'h09, 1'b1);
              default: ;
            endcase
          end
        end
        default: begin
          code_pt = {code_pt[11:0], nibble_of(c)};
          if (hex_cnt != HEX_LAST) begin
            hex_cnt = hex_cnt + 2'd1;
          end else begin
            hex_cnt = 2'd0;
            mode = MODE_TEXT;
            emit_utf8(code_pt);
          end
        end
      endcase
    endfunction

    // one accepted output transfer
    function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
      unesc_res_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d byte %02h last %0d", kind, data, last);
        return;
      end
      exp_r = expected_q.pop_front();
      if (kind !== exp_r.kind || data !== exp_r.data || last !== exp_r.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected kind %0d byte %02h last %0d, got kind %0d byte %02h last %0d",
                   exp_r.kind, exp_r.data, exp_r.last, kind, data, last);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

  endclass

endpackage

// File: bench/json_string_unescape_test.sv
// self-checking testbench for the json string unescaper with random idling on both sides
`timescale 1ns / 100ps

module json_string_unescape_test;

  import jsu_pkg::*;
  import jsu_unescape_sb_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 200;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last;

  unescape_scoreboard sb = new();
  logic [7:0] stim_q[$];

  int gap_max     = 0;
  int stall_max   = 0;
  bit hold_req    = 1'b0;
  int hold_left   = 0;
  int run_left    = 0;
  logic stall_state = 1'b0;
  int quiet_cycles  = 0;

  json_string_unescape u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_byte_i   (in_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .out_byte_o  (out_byte),
    .last_o      (last)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // transfer monitors
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) sb.note_byte(in_byte);
    if (rst_ni && out_valid && !out_stall) sb.check_result(kind, out_byte, last);
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("json_string_unescape verification failed");
      $finish;
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_max == 0) begin
      out_stall <= 1'b0;
    end else begin
      if (run_left == 0) begin
        stall_state = ~stall_state;
        run_left = $urandom_range(1, stall_max);
      end
      run_left--;
      out_stall <= stall_state;
    end
  end

  function automatic logic [7:0] escape_letter(int idx);
    case (idx)
      0: return CHAR_QUOTE;
      1: return CHAR_BACKSLASH;
      2: return CHAR_SLASH;
      3: return CHAR_B;
      4: return CHAR_F;
      5: return CHAR_N;
      6: return CHAR_R;
      default: return CHAR_T;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) stim_q.push_back(s[i]);
  endfunction

  function automatic void add_random_string();
    int n;
    int sel;
    int sz;
    logic [7:0] c;
    logic [15:0] cp;
    stim_q.push_back(CHAR_QUOTE);
    n = $urandom_range(0, 8);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        do c = 8'($urandom_range(0, 255)); while (c == CHAR_QUOTE || c == CHAR_BACKSLASH);
        stim_q.push_back(c);
      end else if (sel < 68) begin
        stim_q.push_back(CHAR_BACKSLASH);
        stim_q.push_back(escape_letter($urandom_range(0, 7)));
      end else if (sel < 75) begin
        stim_q.push_back(CHAR_BACKSLASH);
        stim_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        stim_q.push_back(CHAR_BACKSLASH);
        stim_q.push_back(CHAR_U);
        sz = $urandom_range(0, 2);
        cp = 16'($urandom);
        if (sz == 0) cp = cp & 16'h007f;
        else if (sz == 1) cp = cp & 16'h07ff;
        for (int k = 3; k >= 0; k--) begin
          if ($urandom_range(0, 9) == 0) stim_q.push_back(8'($urandom_range(0, 255)));
          else stim_q.push_back(hex_char(cp[4*k +: 4]));
        end
      end
    end
    // most strings are closed, some are left open
    if ($urandom_range(0, 9) != 0) stim_q.push_back(CHAR_QUOTE);
  endfunction

  function automatic void add_random_phase(int count);
    int start;
    int noise;
    start = stim_q.size();
    while (stim_q.size() - start < count) begin
      if ($urandom_range(0, 9) == 0) begin
        noise = $urandom_range(1, 3);
        repeat (noise) stim_q.push_back(8'($urandom_range(0, 255)));
      end
      add_random_string();
    end
  endfunction

  task automatic send_byte(logic [7:0] b);
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_all();
    int burst;
    int gap;
    burst = $urandom_range(1, 16);
    while (stim_q.size() > 0) begin
      send_byte(stim_q.pop_front());
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: not a string, byte extremes, escapes, utf-8 sizes, non-hex digits
    gap_max = 3;
    stall_max = 3;
    stim_q.push_back(8'hff);
    stim_q.push_back(CHAR_QUOTE);
    stim_q.push_back(8'h00);
    stim_q.push_back(8'hff);
    push_text("\\n\\x\\uFfFf\\u\"\\z0\\u07fF\"");
    send_all();
    wait_drained();

    gap_max = 6;
    stall_max = 6;
    add_random_phase(110);
    send_all();
    wait_drained();

    // receiver holds off while the sender keeps offering
    gap_max = 0;
    hold_req = 1'b1;
    add_random_phase(50);
    send_all();
    wait_drained();

    gap_max = 0;
    stall_max = 0;
    add_random_phase(50);
    send_all();
    wait_drained();

    gap_max = 10;
    stall_max = 24;
    add_random_phase(50);
    send_all();
    wait_drained();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("json_string_unescape verification clean");
    end else begin
      $display("json_string_unescape verification failed");
    end
    $finish;
  end

endmodule
